/* sv/btt_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and types for the byte stream to ternary digit converter.
package btt_pkg;

    localparam int BYTE_W          = 8;
    localparam int BYTES_PER_WORD  = 8;
    localparam int WORD_W          = BYTE_W * BYTES_PER_WORD;
    localparam int CNT_W           = $clog2(BYTES_PER_WORD);
    localparam int TRITS_FULL      = 41;
    localparam int TERN_W          = 2 * TRITS_FULL;
    localparam int TRITS_PER_WORD_DEF = 41;
    localparam int POS_W           = 6;
    localparam int BITS_PER_STEP   = 2;
    localparam int CONV_STEPS      = WORD_W / BITS_PER_STEP;
    localparam int STEP_W          = $clog2(CONV_STEPS);
    localparam int Q_DEPTH         = 2;
    localparam int Q_PTR_W         = $clog2(Q_DEPTH);
    localparam int Q_CNT_W         = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] word;
    } t_word_xfer;

endpackage

/* sv/btt_front.sv */
`timescale 1ns / 1ps
// Front end: packs bytes big-endian into words and pads a short final word.
module btt_front import btt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_last,
    input  logic              i_q_full,
    output t_word_xfer        o_push
);

    logic [WORD_W-1:0] r_acc;
    logic [CNT_W-1:0]  r_cnt;
    logic [WORD_W-1:0] n_acc;
    logic [CNT_W:0]    held;
    logic [CNT_W:0]    pad;
    logic              accept;
    logic              complete;

    assign o_ready  = !i_q_full;
    assign accept   = i_valid && o_ready;
    assign n_acc    = {r_acc[WORD_W-BYTE_W-1:0], i_byte};
    assign held     = {1'b0, r_cnt} + (CNT_W+1)'(1);
    assign complete = (held == (CNT_W+1)'(BYTES_PER_WORD)) || i_last;
    assign pad      = (CNT_W+1)'(BYTES_PER_WORD) - held;

    always_comb begin
        o_push.valid = accept && complete;
        o_push.word  = n_acc << {pad[CNT_W-1:0], 3'b000};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_cnt <= '0;
        end else if (accept) begin
            if (complete) begin
                r_acc <= '0;
                r_cnt <= '0;
            end else begin
                r_acc <= n_acc;
                r_cnt <= held[CNT_W-1:0];
            end
        end
    end

endmodule

/* sv/btt_queue.sv */
`timescale 1ns / 1ps
// Short word queue between the byte packer and the digit converter.
module btt_queue import btt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_word_xfer i_push,
    input  logic       i_pop,
    output logic       o_full,
    output t_word_xfer o_head
);

    logic [WORD_W-1:0]  r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               do_pop;

    assign o_full      = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.word  = r_mem[r_rd_ptr];
    assign do_pop       = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push.valid, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* sv/btt_back.sv */
`timescale 1ns / 1ps
// Back end: converts words to base-3 digits two bits a cycle and sends the digits out.
module btt_back import btt_pkg::*; #(
    parameter int TRITS_PER_WORD = TRITS_PER_WORD_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_word_xfer i_head,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_trit,
    output logic [POS_W-1:0] o_pos,
    output logic       o_last
);

    localparam int EMIT_W = 2 * TRITS_PER_WORD;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(TRITS_PER_WORD - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } t_conv_state;

    t_conv_state       r_state;
    logic [WORD_W-1:0] r_word;
    logic [TERN_W-1:0] r_tern;
    logic [STEP_W-1:0] r_step;
    logic [EMIT_W-1:0] r_emit;
    logic [POS_W-1:0]  r_pos;
    logic              r_emit_busy;
    logic [TERN_W-1:0] n_tern;
    logic [EMIT_W-1:0] n_emit;
    logic              out_fire;
    logic              emit_free;
    logic              handoff;

    function automatic logic [TERN_W-1:0] tern_double(input logic [TERN_W-1:0] t,
                                                      input logic bit_in);
        logic [TRITS_FULL-1:0] a;
        logic [TRITS_FULL-1:0] b;
        logic [TRITS_FULL-1:0] s;
        logic [TRITS_FULL-1:0] c;
        logic [TERN_W-1:0]     r;
        logic [1:0]            d;
        for (int i = 0; i < TRITS_FULL; i++) begin
            d    = t[2*i +: 2];
            a[i] = (d != 2'd0);
            b[i] = (d == 2'd2);
        end
        s = a + b + TRITS_FULL'(bit_in);
        c = s ^ a ^ b;
        for (int i = 0; i < TRITS_FULL; i++) begin
            d = t[2*i +: 2];
            case (d)
                2'd0:    r[2*i +: 2] = c[i] ? 2'd1 : 2'd0;
                2'd1:    r[2*i +: 2] = c[i] ? 2'd0 : 2'd2;
                2'd2:    r[2*i +: 2] = c[i] ? 2'd2 : 2'd1;
                default: r[2*i +: 2] = 2'd0;
            endcase
        end
        return r;
    endfunction

    assign n_tern    = tern_double(tern_double(r_tern, r_word[WORD_W-1]), r_word[WORD_W-2]);
    assign out_fire  = r_emit_busy && i_ready;
    assign emit_free = !r_emit_busy || (out_fire && (r_pos == LAST_POS));
    assign handoff   = (r_state == ST_HOLD) && emit_free;
    assign o_pop     = (r_state == ST_IDLE) && i_head.valid;

    always_comb begin
        n_emit = '0;
        n_emit[TERN_W-1:0] = r_tern;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_head.valid) begin
                        r_word  <= i_head.word;
                        r_tern  <= '0;
                        r_step  <= '0;
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_tern <= n_tern;
                    r_word <= {r_word[WORD_W-BITS_PER_STEP-1:0], {BITS_PER_STEP{1'b0}}};
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(CONV_STEPS - 1)) begin
                        r_state <= ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (emit_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit_busy <= 1'b0;
            r_pos       <= '0;
        end else if (handoff) begin
            r_emit_busy <= 1'b1;
            r_emit      <= n_emit;
            r_pos       <= '0;
        end else if (out_fire) begin
            if (r_pos == LAST_POS) begin
                r_emit_busy <= 1'b0;
            end
            r_emit <= {2'b00, r_emit[EMIT_W-1:2]};
            r_pos  <= r_pos + 1'b1;
        end
    end

    assign o_valid = r_emit_busy;
    assign o_trit  = (r_emit[1:0] == 2'd2) ? 2'b11 : r_emit[1:0];
    assign o_pos   = r_pos;
    assign o_last  = (r_pos == LAST_POS);

endmodule

/* sv/byte_stream_to_ternary_digits_core.sv */
`timescale 1ns / 1ps
// Top level of the byte stream to ternary digit converter.
//
// The slave stream takes one byte per transfer in tdata; tlast marks the final
// byte of a message. Eight bytes form one 64-bit word, first byte most
// significant. A message that ends part way through a word is padded with zero
// bytes at the low end. Each word leaves on the master stream as TRITS_PER_WORD
// transfers, least significant digit first, each carrying the digit (0, 1 or
// 2, the last coded as 2'b11) and its position; tlast is high on the last digit
// of the word. A completed word enters a two-entry queue. The converter takes
// two bits a cycle. Digits leave at one per cycle while the receiver is ready,
// and the next word is converted in the background meanwhile. When the
// receiver stalls, the current digit is held; once the queue is full, tready
// on the slave side drops. Reset empties the partial word, the queue, the
// converter and the output.
module byte_stream_to_ternary_digits_core import btt_pkg::*; #(
    parameter int TRITS_PER_WORD = TRITS_PER_WORD_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] data_byte
    input  logic       i_s_axis_tlast,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [1:0] trit_value, [7:2] trit_position
    output logic       o_m_axis_tlast
);

    t_word_xfer       push;
    t_word_xfer       head;
    logic             q_full;
    logic             pop;
    logic [1:0]       trit;
    logic [POS_W-1:0] pos;

    btt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_byte   (i_s_axis_tdata),
        .i_last   (i_s_axis_tlast),
        .i_q_full (q_full),
        .o_push   (push)
    );

    btt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_head  (head)
    );

    btt_back #(
        .TRITS_PER_WORD (TRITS_PER_WORD)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_trit  (trit),
        .o_pos   (pos),
        .o_last  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {pos, trit};

endmodule
